// ===== sv/smrr_pkg.sv =====
// ----------------------------------------------------------------------------
// smrr_pkg
// Shared types and constants for the shuffled minimal-standard range RNG.
// ----------------------------------------------------------------------------
package smrr_pkg;

    localparam int          VAL_W    = 31;
    localparam int          PROD_W   = 46;
    localparam int          CNT_W    = 6;
    localparam int          BIT_W    = 5;
    localparam logic [14:0] MUL_A    = 15'd16807;
    localparam logic [30:0] MODULUS  = 31'h7FFF_FFFF;
    localparam logic [5:0]  SEED_TOP = 6'd39;
    localparam logic [4:0]  DIV_TOP  = 5'd30;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEED_MUL,
        S_SEED_RED,
        S_DRAW_MUL,
        S_DRAW_RED,
        S_DIVIDE,
        S_FINISH
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_seed;
        logic load_draw;
        logic seed_mul;
        logic seed_red;
        logic draw_mul;
        logic draw_red;
        logic div_step;
        logic finish;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic seed_last;
        logic ordered;
        logic div_last;
    } t_status;

endpackage

// ===== sv/smrr_ctrl.sv =====
// ----------------------------------------------------------------------------
// smrr_ctrl
// Sequencer for reseed and draw items; issues datapath commands.
// ----------------------------------------------------------------------------
module smrr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_action,
    input  smrr_pkg::t_status i_status,
    output smrr_pkg::t_cmd  o_cmd,
    output logic            o_busy,
    output logic            o_strobe
);
    import smrr_pkg::*;

    t_state r_state, n_state;
    logic   r_strobe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= o_cmd.finish;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_action) begin
                        o_cmd.load_seed = 1'b1;
                        n_state         = S_SEED_MUL;
                    end else begin
                        o_cmd.load_draw = 1'b1;
                        n_state         = S_DRAW_MUL;
                    end
                end
            end
            S_SEED_MUL: begin
                o_cmd.seed_mul = 1'b1;
                n_state        = S_SEED_RED;
            end
            S_SEED_RED: begin
                o_cmd.seed_red = 1'b1;
                n_state        = i_status.seed_last ? S_FINISH : S_SEED_MUL;
            end
            S_DRAW_MUL: begin
                o_cmd.draw_mul = 1'b1;
                n_state        = S_DRAW_RED;
            end
            S_DRAW_RED: begin
                o_cmd.draw_red = 1'b1;
                // reversed bounds need no remainder
                n_state        = i_status.ordered ? S_DIVIDE : S_FINISH;
            end
            S_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;

endmodule

// ===== sv/smrr_dp.sv =====
// ----------------------------------------------------------------------------
// smrr_dp
// Generator step, shuffle table, remainder unit and result registers.
// ----------------------------------------------------------------------------
module smrr_dp #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  smrr_pkg::t_cmd     i_cmd,
    output smrr_pkg::t_status  o_status,
    input  logic signed [31:0] i_seed_value,
    input  logic signed [30:0] i_lower_bound,
    input  logic signed [30:0] i_upper_bound,
    output logic signed [30:0] o_draw_value,
    output logic               o_replaced
);
    import smrr_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    logic [VAL_W-1:0]       r_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [VAL_W-1:0]       r_gen;
    logic [VAL_W-1:0]       r_last;
    logic [PROD_W-1:0]      r_prod;
    logic [CNT_W-1:0]       r_cnt;
    logic [VAL_W-1:0]       r_rdata;
    logic                   r_rvld;
    logic [30:0]            r_lo;
    logic [31:0]            r_span;
    logic                   r_ordered;
    logic                   r_draw;
    logic [VAL_W-1:0]       r_dvd;
    logic [31:0]            r_rem;
    logic [BIT_W-1:0]       r_bit;
    logic [30:0]            r_out_value;
    logic                   r_out_repl;

    logic [31:0]      n_sum;
    logic [VAL_W-1:0] n_fresh;
    logic [VAL_W-1:0] n_value;
    logic [31:0]      n_rem_sh;
    logic [31:0]      n_res;
    logic             n_seed_wr;
    logic             n_wr_en;
    logic [IDX_W-1:0] n_wr_addr;
    logic [IDX_W-1:0] n_rd_addr;

    // x * a mod (2^31 - 1): fold the high bits back onto the low 31 bits
    always_comb begin
        n_sum   = {1'b0, r_prod[VAL_W-1:0]} + {17'b0, r_prod[PROD_W-1:VAL_W]};
        n_fresh = (n_sum >= {1'b0, MODULUS}) ? VAL_W'(n_sum - {1'b0, MODULUS})
                                             : n_sum[VAL_W-1:0];
    end

    assign n_value   = r_rvld ? r_rdata : '0;
    assign n_rem_sh  = {r_rem[30:0], r_dvd[VAL_W-1]};
    assign n_res     = {r_lo[30], r_lo} + r_rem;
    assign n_rd_addr = r_last[IDX_W-1:0];
    assign n_seed_wr = i_cmd.seed_red && (int'(r_cnt) < TABLE_DEPTH);
    assign n_wr_en   = n_seed_wr || i_cmd.draw_red;
    assign n_wr_addr = i_cmd.seed_red ? r_cnt[IDX_W-1:0] : n_rd_addr;

    // shuffle table
    always_ff @(posedge i_clk) begin
        if (n_wr_en) begin
            r_mem[n_wr_addr] <= n_fresh;
        end
        if (i_cmd.draw_mul) begin
            r_rdata <= r_mem[n_rd_addr];
        end
    end

    // control-like state that reset clears
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_gen   <= '0;
            r_last  <= '0;
        end else begin
            if (n_wr_en) begin
                r_valid[n_wr_addr] <= 1'b1;
            end
            if (i_cmd.load_seed) begin
                r_gen <= (i_seed_value < 32'sd1) ? VAL_W'(1) : i_seed_value[VAL_W-1:0];
            end
            if (i_cmd.seed_red) begin
                r_gen <= n_fresh;
                if (r_cnt == '0) begin
                    r_last <= n_fresh;
                end
            end
            if (i_cmd.draw_red) begin
                r_gen  <= n_fresh;
                r_last <= n_value;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_seed) begin
            r_cnt  <= SEED_TOP;
            r_draw <= 1'b0;
        end
        if (i_cmd.load_draw) begin
            r_draw    <= 1'b1;
            r_lo      <= i_lower_bound;
            r_span    <= {i_upper_bound[30], i_upper_bound}
                       - {i_lower_bound[30], i_lower_bound} + 32'd1;
            r_ordered <= (i_lower_bound <= i_upper_bound);
        end
        if (i_cmd.seed_mul || i_cmd.draw_mul) begin
            r_prod <= PROD_W'(r_gen) * PROD_W'(MUL_A);
        end
        if (i_cmd.draw_mul) begin
            r_rvld <= r_valid[n_rd_addr];
        end
        if (i_cmd.seed_red) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
        if (i_cmd.draw_red) begin
            r_dvd <= n_value;
            r_rem <= '0;
            r_bit <= DIV_TOP;
        end
        // restoring remainder, one dividend bit per cycle
        if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[VAL_W-2:0], 1'b0};
            r_rem <= (n_rem_sh >= r_span) ? n_rem_sh - r_span : n_rem_sh;
            r_bit <= r_bit - BIT_W'(1);
        end
        if (i_cmd.finish) begin
            if (!r_draw) begin
                r_out_value <= '0;
                r_out_repl  <= 1'b0;
            end else if (r_ordered) begin
                r_out_value <= n_res[30:0];
                r_out_repl  <= 1'b0;
            end else begin
                r_out_value <= r_lo;
                r_out_repl  <= 1'b1;
            end
        end
    end

    assign o_status.seed_last = (r_cnt == '0);
    assign o_status.ordered   = r_ordered;
    assign o_status.div_last  = (r_bit == '0);
    assign o_draw_value       = r_out_value;
    assign o_replaced         = r_out_repl;

endmodule

// ===== sv/shuffled_minstd_range_rng.sv =====
// ----------------------------------------------------------------------------
// shuffled_minstd_range_rng
// Park-Miller generator with a shuffle table, mapped into a signed range.
//
//   Channel  | Signals                                      | Transfer
//   ---------+----------------------------------------------+----------------------
//   command  | start, busy, i_action, i_seed_value,         | start && !busy
//            | i_lower_bound, i_upper_bound                 |
//   result   | o_valid, o_draw_value, o_replaced            | o_valid, one cycle
//
// Reseed: 40 generator steps, each a multiply and then a modular fold,
//   followed by the finish state and the result strobe.
// Draw: a generator step with the table read, the bit-serial remainder
//   unit over all 31 dividend bits, the finish state and the strobe;
//   reversed bounds skip the remainder.
// Busy drops in the cycle that carries the result strobe; the next command
//   may transfer in that same cycle. The receiver cannot stall.
// Reset clears the generator, last output and the table valid bits.
// ----------------------------------------------------------------------------
module shuffled_minstd_range_rng #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_action,
    input  logic signed [31:0] i_seed_value,
    input  logic signed [30:0] i_lower_bound,
    input  logic signed [30:0] i_upper_bound,
    output logic               o_valid,
    output logic signed [30:0] o_draw_value,
    output logic               o_replaced
);
    import smrr_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    smrr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_action),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy),
        .o_strobe (o_valid)
    );

    smrr_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_seed_value  (i_seed_value),
        .i_lower_bound (i_lower_bound),
        .i_upper_bound (i_upper_bound),
        .o_draw_value  (o_draw_value),
        .o_replaced    (o_replaced)
    );

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("result strobe missing after busy dropped");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_valid))
        else $error("command transfer did not start work");

endmodule
